// File: sv/tbpf_pkg.sv
// Shared types and constants for the tiled background pixel fetch unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tbpf_pkg;

    localparam int VRAM_HALFWORDS       = 32768;
    localparam int VRAM_AW              = $clog2(VRAM_HALFWORDS);
    localparam int SCREEN_WIDTH_DEFAULT = 240;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 9;
    localparam int QUEUE_DEPTH          = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_ENABLE  = 3'd0,
        REG_CHAR_BASE     = 3'd1,
        REG_SCREEN_BASE   = 3'd2,
        REG_COLOR_256     = 3'd3,
        REG_MAP_SIZE      = 3'd4,
        REG_SCROLL_X      = 3'd5,
        REG_SCROLL_Y      = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_BLANK = 2'd1,
        KIND_FETCH = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TILE = 2'd1,
        ST_PIX  = 2'd2
    } back_state_t;

    typedef struct packed {
        logic       layer_enable;
        logic [1:0] char_base_block;
        logic [4:0] screen_base_block;
        logic       color_256;
        logic [1:0] map_size;
        logic [8:0] scroll_x;
        logic [8:0] scroll_y;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [VRAM_AW-1:0] addr;
        logic [15:0]        data;
        logic [2:0]         fine_x;
        logic [2:0]         fine_y;
    } qent_t;

endpackage

// File: sv/tbpf_front.sv
// Front end: classifies an accepted item and forms the map entry address.
// Depends on tbpf_pkg.
module tbpf_front
    import tbpf_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT
)
(
    input  cfg_t        cfg,
    input  logic        operation,
    input  logic [14:0] vram_address,
    input  logic [15:0] write_data,
    input  logic [7:0]  line,
    input  logic [7:0]  column,
    output qent_t       ent
);

    localparam logic [9:0] SCREEN_W = 10'(SCREEN_WIDTH);

    logic        wide;
    logic        tall;
    logic [9:0]  sum_x;
    logic [9:0]  sum_y;
    logic [8:0]  px;
    logic [8:0]  py;
    logic [1:0]  blk;
    logic [11:0] map_index;
    logic [15:0] map_addr;
    logic        blank;

    always_comb
    begin
        wide      = cfg.map_size[0];
        tall      = cfg.map_size[1];
        sum_x     = {2'b00, column} + {1'b0, cfg.scroll_x};
        sum_y     = {2'b00, line} + {1'b0, cfg.scroll_y};
        px        = {sum_x[8] & wide, sum_x[7:0]};
        py        = {sum_y[8] & tall, sum_y[7:0]};
        blk       = wide ? {py[8], px[8]} : {1'b0, py[8]};
        map_index = {blk, py[7:3], px[7:3]};
        map_addr  = {1'b0, cfg.screen_base_block, 10'd0} + {4'd0, map_index};
        blank     = !cfg.layer_enable || ({2'b00, column} >= SCREEN_W);

        ent.data   = write_data;
        ent.fine_x = px[2:0];
        ent.fine_y = py[2:0];
        if (!operation)
        begin
            ent.kind = KIND_WRITE;
            ent.addr = VRAM_AW'(vram_address);
        end
        else if (blank)
        begin
            ent.kind = KIND_BLANK;
            ent.addr = VRAM_AW'(map_addr);
        end
        else
        begin
            ent.kind = KIND_FETCH;
            ent.addr = VRAM_AW'(map_addr);
        end
    end

endmodule

// File: sv/tbpf_queue.sv
// Two-entry item queue between front and back end.
// Depends on tbpf_pkg.
module tbpf_queue
    import tbpf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_ent,
    input  logic  pop,
    output qent_t head,
    output logic  empty,
    output logic  full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    qent_t           slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == (PW+1)'(QUEUE_DEPTH));
        do_push     = push && !full;
        do_pop      = pop && !empty;
        head        = slots_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

// File: sv/tbpf_back.sv
// Back end: owns video memory, runs writes and the map-then-tile read sequence.
// Depends on tbpf_pkg.
module tbpf_back
    import tbpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  qent_t      head,
    input  logic       empty,
    output logic       pop,
    output logic       done,
    output logic       enabled,
    output logic [7:0] pixel_index
);

    logic [15:0]        mem [VRAM_HALFWORDS];
    logic [15:0]        rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [VRAM_AW-1:0] mem_addr;

    back_state_t state_reg;
    back_state_t state_next;
    logic        done_reg;
    logic        done_next;
    logic        enabled_reg;
    logic        enabled_next;
    logic [7:0]  pix_reg;
    logic [7:0]  pix_next;
    logic [2:0]  fx_reg;
    logic [2:0]  fx_next;
    logic [2:0]  fy_reg;
    logic [2:0]  fy_next;
    logic [2:0]  x_reg;
    logic [2:0]  x_next;
    logic [3:0]  bank_reg;
    logic [3:0]  bank_next;
    logic        hi_reg;
    logic        hi_next;

    logic [2:0]  tx;
    logic [2:0]  ty;
    logic [16:0] byte_addr;
    logic [7:0]  sel_byte;
    logic [3:0]  nib;

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        enabled_next = enabled_reg;
        pix_next     = pix_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        x_next       = x_reg;
        bank_next    = bank_reg;
        hi_next      = hi_reg;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = head.addr;

        tx = fx_reg ^ {3{rd_data_reg[10]}};
        ty = fy_reg ^ {3{rd_data_reg[11]}};
        if (cfg.color_256)
        begin
            byte_addr = {1'b0, cfg.char_base_block, 14'd0}
                      + {1'b0, rd_data_reg[9:0], 6'd0}
                      + {11'd0, ty, tx};
        end
        else
        begin
            byte_addr = {1'b0, cfg.char_base_block, 14'd0}
                      + {2'b00, rd_data_reg[9:0], 5'd0}
                      + {12'd0, ty, tx[2:1]};
        end
        sel_byte = hi_reg ? rd_data_reg[15:8] : rd_data_reg[7:0];
        nib      = x_reg[0] ? sel_byte[7:4] : sel_byte[3:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        KIND_BLANK:
                        begin
                            done_next    = 1'b1;
                            enabled_next = 1'b0;
                            pix_next     = 8'd0;
                        end
                        KIND_FETCH:
                        begin
                            mem_re     = 1'b1;
                            fx_next    = head.fine_x;
                            fy_next    = head.fine_y;
                            state_next = ST_TILE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TILE:
            begin
                mem_re     = 1'b1;
                mem_addr   = VRAM_AW'(byte_addr[16:1]);
                hi_next    = byte_addr[0];
                x_next     = tx;
                bank_next  = rd_data_reg[15:12];
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                done_next    = 1'b1;
                enabled_next = 1'b1;
                pix_next     = cfg.color_256 ? sel_byte : {bank_reg, nib};
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        enabled_reg <= enabled_next;
        pix_reg     <= pix_next;
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        x_reg       <= x_next;
        bank_reg    <= bank_next;
        hi_reg      <= hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= head.data;
        end
        else if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign done        = done_reg;
    assign enabled     = enabled_reg;
    assign pixel_index = pix_reg;

endmodule

// File: sv/tiled_background_pixel_fetch_unit.sv
// Top level of the tiled background pixel fetch unit: config registers, front, queue, back.
// Depends on tbpf_pkg, tbpf_front, tbpf_queue and tbpf_back.
//
//   channel   handshake             payload
//   item in   start, busy           operation, vram_address, write_data, line, column
//   result    done (one cycle)      enabled, pixel_index
//   config    cfg_write             cfg_index, cfg_data
//
// A write item is stored in video memory with no result; a render of a disabled layer or
// an off-screen column is answered from idle; a fetched pixel steps through map read,
// tile read and format on the single video memory port; the result strobe is registered.
// Reset clears config, queue and sequencer; video memory holds garbage until written.
// busy rises while the two-entry queue is full; results are never held back.
module tiled_background_pixel_fetch_unit
    import tbpf_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [14:0]           vram_address,
    input  logic [15:0]           write_data,
    input  logic [7:0]            line,
    input  logic [7:0]            column,
    output logic                  done,
    output logic                  enabled,
    output logic [7:0]            pixel_index,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    qent_t front_ent;
    qent_t head;
    logic  q_empty;
    logic  q_full;
    logic  q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LAYER_ENABLE: cfg_next.layer_enable      = cfg_data[0];
                REG_CHAR_BASE:    cfg_next.char_base_block   = cfg_data[1:0];
                REG_SCREEN_BASE:  cfg_next.screen_base_block = cfg_data[4:0];
                REG_COLOR_256:    cfg_next.color_256         = cfg_data[0];
                REG_MAP_SIZE:     cfg_next.map_size          = cfg_data[1:0];
                REG_SCROLL_X:     cfg_next.scroll_x          = cfg_data[8:0];
                REG_SCROLL_Y:     cfg_next.scroll_y          = cfg_data[8:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tbpf_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_front (
        .cfg          (cfg_reg),
        .operation    (operation),
        .vram_address (vram_address),
        .write_data   (write_data),
        .line         (line),
        .column       (column),
        .ent          (front_ent)
    );

    tbpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (start),
        .push_ent (front_ent),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    tbpf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .empty       (q_empty),
        .pop         (q_pop),
        .done        (done),
        .enabled     (enabled),
        .pixel_index (pixel_index)
    );

    assign busy = q_full;

endmodule
